@@ rtl/tlssni_pkg.sv @@
// ----------------------------------------------------------------------------
// tlssni_pkg
// Shared types and constants of the TLS ClientHello server name locator.
// ----------------------------------------------------------------------------
package tlssni_pkg;

  typedef enum logic [3:0] {
    PH_HDR          = 4'd0,
    PH_CV           = 4'd1,
    PH_RANDOM       = 4'd2,
    PH_SID_LEN      = 4'd3,
    PH_SID          = 4'd4,
    PH_CS_LEN       = 4'd5,
    PH_CS           = 4'd6,
    PH_CM_LEN       = 4'd7,
    PH_CM           = 4'd8,
    PH_EXT_LEN      = 4'd9,
    PH_EXT_HDR      = 4'd10,
    PH_EXT_SKIP     = 4'd11,
    PH_SNI_LIST_LEN = 4'd12,
    PH_SNI_TYPE     = 4'd13,
    PH_SNI_HLEN     = 4'd14,
    PH_DONE         = 4'd15
  } phase_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned OffW     = 17;
  localparam int unsigned LenW     = 16;

  localparam logic [CfgIdxW-1:0] CFG_SPLIT_MODE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FIXED_OFFSET = 1'b1;

  localparam logic [1:0] SPLIT_FIXED  = 2'd0;
  localparam logic [1:0] SPLIT_FIRST  = 2'd1;
  localparam logic [1:0] SPLIT_BEFORE = 2'd2;
  localparam logic [1:0] SPLIT_MIDDLE = 2'd3;

  localparam logic [7:0] REC_TYPE_HANDSHAKE = 8'h16;
  localparam logic [7:0] REC_MAJOR_VERSION  = 8'h03;
  localparam logic [7:0] HS_TYPE_HELLO      = 8'h01;
  localparam int unsigned RandomLen         = 32;

endpackage

@@ rtl/tls_client_hello_sni_locator_unit.sv @@
// ----------------------------------------------------------------------------
// tls_client_hello_sni_locator_unit
// Streaming locator of the server name in a TLS ClientHello payload.
// ----------------------------------------------------------------------------
// Usage:
//   Feed payload bytes on the input channel (data_byte_i, last_i) with
//   in_valid_i / in_ready_o, one byte per transfer. Every byte is parsed in
//   the cycle it is taken; only the transfer carrying last_i produces a
//   result on the output channel (out_valid_o / out_ready_i) in the next
//   cycle, from the output register.
//   Throughput: one byte per clock while in_ready_o is high. The parse state
//   lives in one set of registers updated by a single layer of logic per
//   byte, so the rate is set by that update path alone.
//   Stall: while a result waits and out_ready_i is low, in_ready_o drops;
//   it is high again in the cycle the result is taken.
//   Reset: clears all parse state, split_mode to 3, fixed_split_offset to 0.
//   Configuration: cfg_valid_i / cfg_ready_o, index 0 split_mode, index 1
//   fixed_split_offset; write only while the block is idle.
//   After each result all parse state returns to its reset value.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_locator_unit #(
  parameter int unsigned PB = 17
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlssni_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tlssni_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hello_present_o,
  output logic [tlssni_pkg::LenW-1:0]        record_version_o,
  output logic [tlssni_pkg::LenW-1:0]        client_version_o,
  output logic [tlssni_pkg::OffW-1:0]        record_end_o,
  output logic [tlssni_pkg::OffW-1:0]        sni_ext_offset_o,
  output logic [tlssni_pkg::OffW-1:0]        host_offset_o,
  output logic [tlssni_pkg::LenW-1:0]        host_length_o,
  output logic [tlssni_pkg::OffW-1:0]        split_offset_o
);
  import tlssni_pkg::*;

  // sums of a position and a field value of up to 24 bits
  localparam int unsigned SW = ((PB > 24) ? PB : 24) + 1;
  localparam logic [PB-1:0] PosMax = '1;

  function automatic logic [PB-1:0] sat_pos(input logic [SW-1:0] x);
    sat_pos = (x > SW'(PosMax)) ? PosMax : x[PB-1:0];
  endfunction

  // configuration
  logic [1:0]          split_mode_q;
  logic [CfgDataW-1:0] fixed_off_q;

  // parse state
  logic [PB-1:0] bpos_q, bpos_d;
  phase_e        ph_q, ph_d;
  logic [23:0]   acc_q, acc_d;
  logic [16:0]   skip_q, skip_d;
  logic [PB-1:0] rec_end_q, rec_end_d, hs_end_q, hs_end_d, ext_end_q, ext_end_d;
  logic [PB-1:0] cur_end_q, cur_end_d, nl_end_q, nl_end_d;
  logic [15:0]   rv_q, rv_d, cv_q, cv_d, hlen_q, hlen_d;
  logic [PB-1:0] sni_off_q, sni_off_d, host_off_q, host_off_d;
  logic [2:0]    flags_q, flags_d;

  // output register
  logic                out_valid_q;
  logic                present_q;
  logic [15:0]         o_rv_q, o_cv_q, o_hl_q;
  logic [OffW-1:0]     o_re_q, o_so_q, o_ho_q, o_sp_q;

  logic          in_xfer;
  logic [PB-1:0] pos;
  logic [SW-1:0] pos_w;
  logic [23:0]   acc_sh;
  logic [16:0]   skip_dec;

  // deferred actions of one byte, resolved in order
  logic          fin, fin_ok;
  logic          do_skip, do_after, do_next, do_begin;
  phase_e        sk_ph, af_ph, bg_ph;
  logic [16:0]   sk_n;
  logic [2:0]    bg_n;
  logic [PB-1:0] bg_lim;

  // result computation
  logic          r_present;
  logic [15:0]   r_rv, r_cv, r_hl;
  logic [PB-1:0] r_re, r_so, r_ho, r_sp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign pos         = bpos_q + PB'(1);
  assign pos_w       = SW'(pos);

  always_comb begin
    bpos_d    = bpos_q;
    ph_d      = ph_q;
    acc_d     = acc_q;
    skip_d    = skip_q;
    rec_end_d = rec_end_q;
    hs_end_d  = hs_end_q;
    ext_end_d = ext_end_q;
    cur_end_d = cur_end_q;
    nl_end_d  = nl_end_q;
    rv_d      = rv_q;
    cv_d      = cv_q;
    hlen_d    = hlen_q;
    sni_off_d = sni_off_q;
    host_off_d = host_off_q;
    flags_d   = flags_q;
    fin = 1'b0; fin_ok = 1'b0;
    do_skip = 1'b0; do_after = 1'b0; do_next = 1'b0; do_begin = 1'b0;
    sk_ph = PH_DONE; af_ph = PH_DONE; bg_ph = PH_DONE;
    sk_n = '0; bg_n = '0; bg_lim = '0;
    acc_sh   = {acc_q[15:0], data_byte_i};
    skip_dec = skip_q - 17'd1;

    // parse the byte, unless the position has saturated
    if (in_xfer && (bpos_q != PosMax)) begin
      bpos_d = pos;
      if (ph_q == PH_DONE) begin
        // ignore trailing bytes
      end else if (ph_q == PH_HDR) begin
        acc_d = acc_sh;
        unique case (bpos_q)
          PB'(0): begin
            if (data_byte_i != REC_TYPE_HANDSHAKE) begin
              flags_d[0] = 1'b1;
              ph_d = PH_DONE;
            end
            acc_d = '0;
          end
          PB'(2): begin
            rv_d = acc_sh[15:0];
            if (acc_sh[15:8] != REC_MAJOR_VERSION) begin
              flags_d[0] = 1'b1;
              ph_d = PH_DONE;
            end
            acc_d = '0;
          end
          PB'(4): begin
            rec_end_d = sat_pos(SW'(5) + SW'(acc_sh[15:0]));
            acc_d = '0;
          end
          PB'(5): begin
            if (data_byte_i != HS_TYPE_HELLO) begin
              flags_d[1] = 1'b1;
              ph_d = PH_DONE;
            end
            acc_d = '0;
          end
          PB'(8): begin
            hs_end_d = sat_pos(SW'(9) + SW'(acc_sh));
            if (SW'(11 + RandomLen) > SW'(hs_end_d)) begin
              fin = 1'b1;
            end else begin
              do_begin = 1'b1; bg_ph = PH_CV; bg_n = 3'd2; bg_lim = hs_end_d;
            end
          end
          default: ;
        endcase
      end else if (skip_q == '0) begin
        fin = 1'b1;
      end else begin
        skip_d = skip_dec;
        if (ph_q == PH_RANDOM || ph_q == PH_SID || ph_q == PH_CS ||
            ph_q == PH_CM || ph_q == PH_EXT_SKIP) begin
          if (skip_dec == '0) begin
            do_after = 1'b1; af_ph = ph_q;
          end
        end else begin
          // collapse the extension type to a non-zero flag
          if (ph_q == PH_EXT_HDR && skip_dec == 17'd2) begin
            acc_sh = {23'd0, (acc_sh[15:0] != '0)};
          end
          acc_d = acc_sh;
          if (skip_dec == '0) begin
            unique case (ph_q)
              PH_CV: begin
                cv_d = acc_sh[15:0];
                do_skip = 1'b1; sk_ph = PH_RANDOM; sk_n = 17'(RandomLen);
              end
              PH_SID_LEN, PH_CS_LEN, PH_CM_LEN: begin
                if (pos_w + SW'(acc_sh) > SW'(hs_end_q)) begin
                  fin = 1'b1;
                end else begin
                  do_skip = 1'b1;
                  sk_n = acc_sh[16:0];
                  sk_ph = (ph_q == PH_SID_LEN) ? PH_SID :
                          (ph_q == PH_CS_LEN) ? PH_CS : PH_CM;
                end
              end
              PH_EXT_LEN: begin
                if (pos_w + SW'(acc_sh) > SW'(hs_end_q)) begin
                  fin = 1'b1;
                end else begin
                  ext_end_d = sat_pos(pos_w + SW'(acc_sh));
                  do_next = 1'b1;
                end
              end
              PH_EXT_HDR: begin
                if (pos_w + SW'(acc_sh[15:0]) > SW'(ext_end_q)) begin
                  fin = 1'b1;
                end else begin
                  cur_end_d = sat_pos(pos_w + SW'(acc_sh[15:0]));
                  if (acc_sh[23:16] != '0) begin
                    do_skip = 1'b1; sk_ph = PH_EXT_SKIP; sk_n = {1'b0, acc_sh[15:0]};
                  end else begin
                    sni_off_d = pos - PB'(4);
                    if (acc_sh[15:0] < 16'd2) begin
                      fin = 1'b1;
                    end else begin
                      do_begin = 1'b1; bg_ph = PH_SNI_LIST_LEN; bg_n = 3'd2;
                      bg_lim = cur_end_d;
                    end
                  end
                end
              end
              PH_SNI_LIST_LEN: begin
                if (pos_w + SW'(acc_sh) > SW'(cur_end_q)) begin
                  fin = 1'b1;
                end else begin
                  nl_end_d = sat_pos(pos_w + SW'(acc_sh));
                  if (pos_w + SW'(3) > SW'(nl_end_d)) begin
                    fin = 1'b1;
                  end else begin
                    do_begin = 1'b1; bg_ph = PH_SNI_TYPE; bg_n = 3'd1;
                    bg_lim = nl_end_d;
                  end
                end
              end
              PH_SNI_TYPE: begin
                if (acc_sh != '0) begin
                  fin = 1'b1; fin_ok = 1'b1;
                end else begin
                  do_begin = 1'b1; bg_ph = PH_SNI_HLEN; bg_n = 3'd2; bg_lim = nl_end_q;
                end
              end
              PH_SNI_HLEN: begin
                if (pos_w + SW'(acc_sh) > SW'(nl_end_q)) begin
                  fin = 1'b1;
                end else begin
                  host_off_d = pos;
                  hlen_d = acc_sh[15:0];
                  fin = 1'b1; fin_ok = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
    end

    // start a skip; an empty one moves on at once
    if (do_skip) begin
      if (sk_n == '0) begin
        do_after = 1'b1; af_ph = sk_ph;
      end else begin
        ph_d = sk_ph; skip_d = sk_n;
      end
    end

    // choose the field that follows a skipped block
    if (do_after) begin
      unique case (af_ph)
        PH_RANDOM: begin
          do_begin = 1'b1; bg_ph = PH_SID_LEN; bg_n = 3'd1; bg_lim = hs_end_d;
        end
        PH_SID: begin
          do_begin = 1'b1; bg_ph = PH_CS_LEN; bg_n = 3'd2; bg_lim = hs_end_d;
        end
        PH_CS: begin
          do_begin = 1'b1; bg_ph = PH_CM_LEN; bg_n = 3'd1; bg_lim = hs_end_d;
        end
        PH_CM: begin
          if (pos_w + SW'(2) > SW'(hs_end_d)) begin
            fin = 1'b1; fin_ok = 1'b1;
          end else begin
            do_begin = 1'b1; bg_ph = PH_EXT_LEN; bg_n = 3'd2; bg_lim = hs_end_d;
          end
        end
        default: do_next = 1'b1;
      endcase
    end

    // advance to the next extension header, or end the list
    if (do_next) begin
      if (pos_w + SW'(4) > SW'(ext_end_d)) begin
        fin = 1'b1; fin_ok = 1'b1;
      end else begin
        do_begin = 1'b1; bg_ph = PH_EXT_HDR; bg_n = 3'd4; bg_lim = ext_end_d;
      end
    end

    // open a fixed-size field if it fits inside its limit
    if (do_begin) begin
      if (pos_w + SW'(bg_n) > SW'(bg_lim)) begin
        fin = 1'b1; fin_ok = 1'b0;
      end else begin
        ph_d = bg_ph; skip_d = {14'd0, bg_n}; acc_d = '0;
      end
    end

    if (fin) begin
      if (fin_ok) flags_d[2] = 1'b1;
      ph_d = PH_DONE;
    end
  end

  // result of the payload as seen after this byte
  always_comb begin
    r_present = 1'b0;
    r_rv = '0; r_cv = '0; r_hl = '0;
    r_re = '0; r_so = '0; r_ho = '0; r_sp = '0;
    if (bpos_d >= PB'(5)) begin
      r_rv = rv_d;
      if (!flags_d[0] && rec_end_d <= bpos_d) begin
        r_re = rec_end_d;
        if (bpos_d >= PB'(9) && !flags_d[1] && hs_end_d <= bpos_d) begin
          r_present = flags_d[2];
          r_cv = cv_d;
          r_so = sni_off_d;
          r_ho = host_off_d;
          r_hl = hlen_d;
        end
      end
    end
    if (r_present) begin
      priority if (split_mode_q == SPLIT_FIXED) begin
        r_sp = PB'(fixed_off_q);
      end else if (split_mode_q == SPLIT_FIRST) begin
        r_sp = PB'(1);
      end else if (r_hl == '0) begin
        r_sp = (r_re > PB'(8)) ? (r_re >> 1) : '0;
      end else if (split_mode_q == SPLIT_BEFORE) begin
        r_sp = r_ho;
      end else begin
        r_sp = sat_pos(SW'(r_ho) + SW'(r_hl >> 1));
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_mode_q <= SPLIT_MIDDLE;
      fixed_off_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPLIT_MODE:   split_mode_q <= cfg_data_i[1:0];
        CFG_FIXED_OFFSET: fixed_off_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= '0; ph_q <= PH_HDR; acc_q <= '0; skip_q <= '0;
      rec_end_q <= '0; hs_end_q <= '0; ext_end_q <= '0;
      cur_end_q <= '0; nl_end_q <= '0;
      rv_q <= '0; cv_q <= '0; hlen_q <= '0;
      sni_off_q <= '0; host_off_q <= '0; flags_q <= '0;
    end else if (in_xfer && last_i) begin
      bpos_q <= '0; ph_q <= PH_HDR; acc_q <= '0; skip_q <= '0;
      rec_end_q <= '0; hs_end_q <= '0; ext_end_q <= '0;
      cur_end_q <= '0; nl_end_q <= '0;
      rv_q <= '0; cv_q <= '0; hlen_q <= '0;
      sni_off_q <= '0; host_off_q <= '0; flags_q <= '0;
    end else begin
      bpos_q <= bpos_d; ph_q <= ph_d; acc_q <= acc_d; skip_q <= skip_d;
      rec_end_q <= rec_end_d; hs_end_q <= hs_end_d; ext_end_q <= ext_end_d;
      cur_end_q <= cur_end_d; nl_end_q <= nl_end_d;
      rv_q <= rv_d; cv_q <= cv_d; hlen_q <= hlen_d;
      sni_off_q <= sni_off_d; host_off_q <= host_off_d; flags_q <= flags_d;
    end
  end

  // output register: hold until taken, load on the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_i) begin
      present_q <= r_present;
      o_rv_q    <= r_rv;
      o_cv_q    <= r_cv;
      o_hl_q    <= r_hl;
      o_re_q    <= r_re[OffW-1:0];
      o_so_q    <= r_so[OffW-1:0];
      o_ho_q    <= r_ho[OffW-1:0];
      o_sp_q    <= r_sp[OffW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hello_present_o  = present_q;
  assign record_version_o = o_rv_q;
  assign client_version_o = o_cv_q;
  assign record_end_o     = o_re_q;
  assign sni_ext_offset_o = o_so_q;
  assign host_offset_o    = o_ho_q;
  assign host_length_o    = o_hl_q;
  assign split_offset_o   = o_sp_q;

endmodule
